>>> rtl/gbc_pkg.sv
// Shared types, constants and round functions for the GOST block cipher pipeline.
`timescale 1ns / 1ps

package gbc_pkg;

    localparam int C_HALF_W = 32;
    localparam int C_KEY_W  = 64;
    localparam int C_WORDS  = 8;

    typedef logic [C_HALF_W-1:0] t_half;
    typedef logic [2:0]          t_word_idx;
    typedef t_half [C_WORDS-1:0] t_key_words;

    typedef enum logic [2:0] {
        CFG_KEY_0_1   = 3'd0,
        CFG_KEY_2_3   = 3'd1,
        CFG_KEY_4_5   = 3'd2,
        CFG_KEY_6_7   = 3'd3,
        CFG_DECRYPT   = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic  valid;
        t_half first;
        t_half second;
    } t_beat;

    localparam logic [0:127][3:0] C_SBOX = {
        4'hC,4'h4,4'h6,4'h2,4'hA,4'h5,4'hB,4'h9,4'hE,4'h8,4'hD,4'h7,4'h0,4'h3,4'hF,4'h1,
        4'h6,4'h8,4'h2,4'h3,4'h9,4'hA,4'h5,4'hC,4'h1,4'hE,4'h4,4'h7,4'hB,4'hD,4'h0,4'hF,
        4'hB,4'h3,4'h5,4'h8,4'h2,4'hF,4'hA,4'hD,4'hE,4'h1,4'h7,4'h4,4'hC,4'h9,4'h6,4'h0,
        4'hC,4'h8,4'h2,4'h1,4'hD,4'h4,4'hF,4'h6,4'h7,4'h0,4'hA,4'h5,4'h3,4'hE,4'h9,4'hB,
        4'h7,4'hF,4'h5,4'hA,4'h8,4'h1,4'h6,4'hD,4'h0,4'h9,4'h3,4'hE,4'hB,4'h4,4'h2,4'hC,
        4'h5,4'hD,4'hF,4'h6,4'h9,4'h2,4'hC,4'hA,4'hB,4'h7,4'h8,4'h1,4'h4,4'h3,4'hE,4'h0,
        4'h8,4'hE,4'h2,4'h5,4'h6,4'h9,4'h1,4'hC,4'hF,4'h4,4'hB,4'h0,4'hD,4'hA,4'h3,4'h7,
        4'h1,4'h7,4'hE,4'hD,4'h0,4'h5,4'h8,4'h3,4'h4,4'hF,4'hA,4'h6,4'h9,4'hC,4'hB,4'h2
    };

    function automatic t_half round_fn(input t_half half, input t_half key);
        t_half      x;
        t_half      y;
        logic [6:0] idx;
        x = half + key;
        y = '0;
        for (int n = 0; n < 8; n++) begin
            idx = {3'(n), x[4*n +: 4]};
            y[4*n +: 4] = C_SBOX[idx];
        end
        return {y[20:0], y[31:21]};
    endfunction

    function automatic t_word_idx key_index(input logic [4:0] rnd, input logic decrypt);
        logic early;
        early = decrypt ? (rnd < 5'd8) : (rnd < 5'd24);
        return early ? rnd[2:0] : ~rnd[2:0];
    endfunction

endpackage

>>> rtl/gbc_round.sv
// One registered Feistel round stage with its own valid bit and stall hand-back.
`timescale 1ns / 1ps

module gbc_round import gbc_pkg::*; #(
    parameter bit LAST = 1'b0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_beat i_beat,
    input  t_half i_key,
    input  logic  i_ready_dn,
    output t_beat o_beat,
    output logic  o_ready_up
);

    logic  r_valid;
    t_half r_first;
    t_half r_second;
    t_half n_mix;

    assign n_mix      = i_beat.second ^ round_fn(i_beat.first, i_key);
    assign o_ready_up = !r_valid || i_ready_dn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready_up) begin
            r_valid <= i_beat.valid;
        end
    end

    // swap halves on every round but the last
    always_ff @(posedge i_clk) begin
        if (o_ready_up && i_beat.valid) begin
            if (LAST) begin
                r_first  <= i_beat.first;
                r_second <= n_mix;
            end else begin
                r_first  <= n_mix;
                r_second <= i_beat.first;
            end
        end
    end

    assign o_beat = '{valid: r_valid, first: r_first, second: r_second};

endmodule

>>> rtl/gost_block_cipher_ecb.sv
// Top level of the pipelined GOST 28147-89 ECB block cipher.
`timescale 1ns / 1ps

// One 64-bit block enters per cycle while o_in_stall is low: each Feistel
// round is one register stage (key add, S-box, rotate, XOR), 32 stages in
// all. A stall on the output backs up stage by stage through a ready chain,
// so empty stages keep filling while a finished block waits. The user must
// write key words and the decrypt bit through the config port only while the
// pipeline is empty; the block itself does not enforce this.

module gost_block_cipher_ecb import gbc_pkg::*; #(
    parameter int ROUND_COUNT = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_block_first,
    input  logic [31:0] i_block_second,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_result_first,
    output logic [31:0] o_result_second
);

    t_key_words r_key;
    logic       r_decrypt;

    t_beat w_beat  [ROUND_COUNT+1];
    logic  w_ready [ROUND_COUNT+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key     <= '0;
            r_decrypt <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEY_0_1: {r_key[0], r_key[1]} <= i_cfg_data;
                CFG_KEY_2_3: {r_key[2], r_key[3]} <= i_cfg_data;
                CFG_KEY_4_5: {r_key[4], r_key[5]} <= i_cfg_data;
                CFG_KEY_6_7: {r_key[6], r_key[7]} <= i_cfg_data;
                CFG_DECRYPT: r_decrypt <= i_cfg_data[0];
                default:     ;
            endcase
        end
    end

    assign w_beat[0] = '{valid: i_in_valid, first: i_block_first, second: i_block_second};
    assign w_ready[ROUND_COUNT] = !i_out_stall;

    for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
        gbc_round #(
            .LAST (g == ROUND_COUNT - 1)
        ) u_round (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_beat     (w_beat[g]),
            .i_key      (r_key[key_index(5'(g), r_decrypt)]),
            .i_ready_dn (w_ready[g+1]),
            .o_beat     (w_beat[g+1]),
            .o_ready_up (w_ready[g])
        );
    end

    assign o_in_stall      = !w_ready[0];
    assign o_out_valid     = w_beat[ROUND_COUNT].valid;
    assign o_result_first  = w_beat[ROUND_COUNT].first;
    assign o_result_second = w_beat[ROUND_COUNT].second;

    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while output can drain");

    a_accept_fills_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> w_beat[1].valid)
        else $error("accepted beat lost at first stage");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule
